@@ rtl/sha1_message_digest_macros.svh @@
// assertion macros for the sha-1 digest rtl
`ifndef SHA1_MESSAGE_DIGEST_MACROS_SVH
`define SHA1_MESSAGE_DIGEST_MACROS_SVH

// same-cycle implication, disabled while reset is asserted
`define SHA1MD_ASSERT_IMP(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("sha1md: same-cycle check failed");

// next-cycle implication, disabled while reset is asserted
`define SHA1MD_ASSERT_NXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("sha1md: next-cycle check failed");

`endif

@@ rtl/sha1md_pkg.sv @@
// shared types, constants and round functions for the sha-1 digest
`default_nettype none

package sha1md_pkg;

    localparam int WordBits      = 32;
    localparam int NumChain      = 5;
    localparam int BlockBytes    = 64;
    localparam int BlockBits     = BlockBytes * 8;
    localparam int ScheduleWords = 16;
    localparam int Rounds        = 80;
    localparam int FillBits      = $clog2(BlockBytes);
    localparam int RoundBits     = $clog2(Rounds);
    localparam int CountBits     = 64;

    localparam logic [FillBits-1:0]  BlockLastIdx = FillBits'(BlockBytes - 1);
    localparam logic [FillBits-1:0]  LenOffset    = FillBits'(56);
    localparam logic [RoundBits-1:0] RoundLast    = RoundBits'(Rounds - 1);
    localparam logic [RoundBits-1:0] RoundSched   = RoundBits'(ScheduleWords);
    localparam logic [7:0]           MarkByte     = 8'h80;
    localparam logic [CountBits-1:0] ByteBits     = CountBits'(8);

    localparam logic [WordBits-1:0] ChainInit [NumChain] = '{
        32'h67452301, 32'hefcdab89, 32'h98badcfe, 32'h10325476, 32'hc3d2e1f0
    };

    localparam logic [WordBits-1:0] RoundK0 = 32'h5a827999;
    localparam logic [WordBits-1:0] RoundK1 = 32'h6ed9eba1;
    localparam logic [WordBits-1:0] RoundK2 = 32'h8f1bbcdc;
    localparam logic [WordBits-1:0] RoundK3 = 32'hca62c1d6;

    localparam logic [RoundBits-1:0] Phase1Start = RoundBits'(20);
    localparam logic [RoundBits-1:0] Phase2Start = RoundBits'(40);
    localparam logic [RoundBits-1:0] Phase3Start = RoundBits'(60);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_PAD_MARK,
        ST_PAD_ZERO,
        ST_PAD_LEN,
        ST_ROUND,
        ST_CHAIN_ADD,
        ST_DONE
    } state_t;

    typedef enum logic [1:0] {
        SEL_INPUT,
        SEL_MARK,
        SEL_ZERO,
        SEL_LEN
    } byte_sel_t;

    typedef struct packed {
        logic      append;
        byte_sel_t byte_sel;
        logic      count_byte;
        logic      round_en;
        logic      chain_add;
        logic      load_digest;
    } cmd_t;

    typedef struct packed {
        logic block_full;
        logic fill_at_len;
        logic round_last;
        logic out_busy;
    } status_t;

    function automatic logic [WordBits-1:0] round_k(input logic [RoundBits-1:0] t);
        logic [WordBits-1:0] k;
        priority if (t < Phase1Start) k = RoundK0;
        else if (t < Phase2Start)     k = RoundK1;
        else if (t < Phase3Start)     k = RoundK2;
        else                          k = RoundK3;
        return k;
    endfunction

    function automatic logic [WordBits-1:0] round_f(
        input logic [RoundBits-1:0] t,
        input logic [WordBits-1:0]  b,
        input logic [WordBits-1:0]  c,
        input logic [WordBits-1:0]  d
    );
        logic [WordBits-1:0] f;
        priority if (t < Phase1Start) f = (b & c) ^ (~b & d);
        else if (t < Phase2Start)     f = b ^ c ^ d;
        else if (t < Phase3Start)     f = (b & c) ^ (b & d) ^ (c & d);
        else                          f = b ^ c ^ d;
        return f;
    endfunction

endpackage

`default_nettype wire

@@ rtl/sha1md_ctrl.sv @@
// control state machine for the sha-1 digest: collection, padding, rounds, output
`default_nettype none

module sha1md_ctrl (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 msg_valid,
    output logic                 msg_stall,
    input  logic                 has_byte,
    input  logic                 last,
    input  sha1md_pkg::status_t  status,
    output sha1md_pkg::cmd_t     cmd
);
    import sha1md_pkg::*;

    state_t state_reg;
    state_t state_next;
    state_t ret_reg;
    state_t ret_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            ret_reg   <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
            ret_reg   <= ret_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        ret_next   = ret_reg;
        cmd        = '0;
        msg_stall  = 1'b1;
        unique case (state_reg)
            ST_IDLE:
            begin
                msg_stall = 1'b0;
                if (msg_valid)
                begin
                    if (has_byte)
                    begin
                        cmd.append     = 1'b1;
                        cmd.byte_sel   = SEL_INPUT;
                        cmd.count_byte = 1'b1;
                    end
                    if (has_byte && status.block_full)
                    begin
                        state_next = ST_ROUND;
                        ret_next   = last ? ST_PAD_MARK : ST_IDLE;
                    end
                    else if (last)
                    begin
                        state_next = ST_PAD_MARK;
                    end
                end
            end
            ST_PAD_MARK:
            begin
                cmd.append   = 1'b1;
                cmd.byte_sel = SEL_MARK;
                state_next   = ST_PAD_ZERO;
                if (status.block_full)
                begin
                    state_next = ST_ROUND;
                    ret_next   = ST_PAD_ZERO;
                end
            end
            ST_PAD_ZERO:
            begin
                if (status.fill_at_len)
                begin
                    state_next = ST_PAD_LEN;
                end
                else
                begin
                    cmd.append   = 1'b1;
                    cmd.byte_sel = SEL_ZERO;
                    if (status.block_full)
                    begin
                        state_next = ST_ROUND;
                        ret_next   = ST_PAD_ZERO;
                    end
                end
            end
            ST_PAD_LEN:
            begin
                cmd.append   = 1'b1;
                cmd.byte_sel = SEL_LEN;
                if (status.block_full)
                begin
                    state_next = ST_ROUND;
                    ret_next   = ST_DONE;
                end
            end
            ST_ROUND:
            begin
                cmd.round_en = 1'b1;
                if (status.round_last)
                begin
                    state_next = ST_CHAIN_ADD;
                end
            end
            ST_CHAIN_ADD:
            begin
                cmd.chain_add = 1'b1;
                state_next    = ret_reg;
            end
            ST_DONE:
            begin
                // hold until the previous digest has been taken
                if (!status.out_busy)
                begin
                    cmd.load_digest = 1'b1;
                    state_next      = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

endmodule

`default_nettype wire

@@ rtl/sha1md_datapath.sv @@
// sha-1 datapath: byte/schedule shift line, round unit, chaining words, output register
`default_nettype none

module sha1md_datapath (
    input  logic                 clk,
    input  logic                 rst_n,
    input  sha1md_pkg::cmd_t     cmd,
    output sha1md_pkg::status_t  status,
    input  logic [7:0]           data_byte,
    input  logic                 digest_stall,
    output logic                 digest_valid,
    output logic [31:0]          digest_word0,
    output logic [31:0]          digest_word1,
    output logic [31:0]          digest_word2,
    output logic [31:0]          digest_word3,
    output logic [31:0]          digest_word4
);
    import sha1md_pkg::*;

    // word 15 holds the oldest schedule word, word 0 the newest
    logic [ScheduleWords-1:0][WordBits-1:0] sched_reg;
    logic [ScheduleWords-1:0][WordBits-1:0] sched_next;
    logic [BlockBits-1:0]                   sched_flat;

    logic [FillBits-1:0]  fill_reg;
    logic [FillBits-1:0]  fill_next;
    logic [CountBits-1:0] bit_count_reg;
    logic [CountBits-1:0] bit_count_next;
    logic [RoundBits-1:0] round_reg;
    logic [RoundBits-1:0] round_next;

    logic [WordBits-1:0] a_reg, b_reg, c_reg, d_reg, e_reg;
    logic [WordBits-1:0] a_next, b_next, c_next, d_next, e_next;
    logic [WordBits-1:0] chain_reg [NumChain];
    logic [WordBits-1:0] chain_next [NumChain];
    logic [WordBits-1:0] digest_reg [NumChain];
    logic                digest_valid_reg;
    logic                digest_valid_next;

    logic [7:0]          append_byte;
    logic                block_start;
    logic [WordBits-1:0] w_mix;
    logic [WordBits-1:0] w_cur;
    logic [WordBits-1:0] t_sum;

    assign sched_flat = sched_reg;

    always_comb
    begin
        unique case (cmd.byte_sel)
            SEL_INPUT: append_byte = data_byte;
            SEL_MARK:  append_byte = MarkByte;
            SEL_ZERO:  append_byte = 8'h00;
            SEL_LEN:   append_byte = bit_count_reg[{~fill_reg[2:0], 3'b000} +: 8];
            default:   append_byte = 8'h00;
        endcase

        block_start = cmd.append && (fill_reg == BlockLastIdx);

        w_mix = sched_reg[2] ^ sched_reg[7] ^ sched_reg[13] ^ sched_reg[15];
        w_cur = (round_reg < RoundSched) ? sched_reg[15] : {w_mix[30:0], w_mix[31]};
        t_sum = {a_reg[26:0], a_reg[31:27]} + round_f(round_reg, b_reg, c_reg, d_reg)
              + e_reg + round_k(round_reg) + w_cur;

        sched_next        = sched_reg;
        fill_next         = fill_reg;
        bit_count_next    = bit_count_reg;
        round_next        = round_reg;
        a_next            = a_reg;
        b_next            = b_reg;
        c_next            = c_reg;
        d_next            = d_reg;
        e_next            = e_reg;
        chain_next        = chain_reg;
        digest_valid_next = digest_valid_reg;

        if (cmd.append)
        begin
            sched_next = {sched_flat[BlockBits-9:0], append_byte};
            fill_next  = fill_reg + 1'b1;
        end

        if (cmd.count_byte)
        begin
            bit_count_next = bit_count_reg + ByteBits;
        end

        if (block_start)
        begin
            round_next = '0;
            a_next     = chain_reg[0];
            b_next     = chain_reg[1];
            c_next     = chain_reg[2];
            d_next     = chain_reg[3];
            e_next     = chain_reg[4];
        end

        if (cmd.round_en)
        begin
            sched_next = {sched_reg[ScheduleWords-2:0], w_cur};
            round_next = round_reg + 1'b1;
            a_next     = t_sum;
            b_next     = a_reg;
            c_next     = {b_reg[1:0], b_reg[31:2]};
            d_next     = c_reg;
            e_next     = d_reg;
        end

        if (cmd.chain_add)
        begin
            chain_next[0] = chain_reg[0] + a_reg;
            chain_next[1] = chain_reg[1] + b_reg;
            chain_next[2] = chain_reg[2] + c_reg;
            chain_next[3] = chain_reg[3] + d_reg;
            chain_next[4] = chain_reg[4] + e_reg;
        end

        if (digest_valid_reg && !digest_stall)
        begin
            digest_valid_next = 1'b0;
        end

        if (cmd.load_digest)
        begin
            chain_next        = ChainInit;
            bit_count_next    = '0;
            digest_valid_next = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fill_reg         <= '0;
            bit_count_reg    <= '0;
            round_reg        <= '0;
            chain_reg        <= ChainInit;
            digest_valid_reg <= 1'b0;
        end
        else
        begin
            fill_reg         <= fill_next;
            bit_count_reg    <= bit_count_next;
            round_reg        <= round_next;
            chain_reg        <= chain_next;
            digest_valid_reg <= digest_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        sched_reg <= sched_next;
        a_reg     <= a_next;
        b_reg     <= b_next;
        c_reg     <= c_next;
        d_reg     <= d_next;
        e_reg     <= e_next;
        if (cmd.load_digest)
        begin
            digest_reg <= chain_reg;
        end
    end

    assign status.block_full  = (fill_reg == BlockLastIdx);
    assign status.fill_at_len = (fill_reg == LenOffset);
    assign status.round_last  = (round_reg == RoundLast);
    assign status.out_busy    = digest_valid_reg && digest_stall;

    assign digest_valid = digest_valid_reg;
    assign digest_word0 = digest_reg[0];
    assign digest_word1 = digest_reg[1];
    assign digest_word2 = digest_reg[2];
    assign digest_word3 = digest_reg[3];
    assign digest_word4 = digest_reg[4];

endmodule

`default_nettype wire

@@ rtl/sha1_message_digest.sv @@
// sha-1 message digest top level: byte request channel in, 160-bit digest request out
// a byte request is taken while msg_stall is low; the 64th byte of a block stalls the input
//   while the round unit runs the 80 rounds and then the chaining add
// bytes of the next block are not taken before that chaining add is done
// a last request then appends the pad bytes, pausing at the length slot, and loads the digest
// reset (rst_n low, asynchronous) loads the initial chaining words and clears counts
`default_nettype none
`include "sha1_message_digest_macros.svh"

module sha1_message_digest (
    input  logic        clk,
    input  logic        rst_n,
    // message byte requests
    input  logic        msg_valid,
    output logic        msg_stall,
    input  logic [7:0]  data_byte,
    input  logic        has_byte,
    input  logic        last,
    // digest requests
    output logic        digest_valid,
    input  logic        digest_stall,
    output logic [31:0] digest_word0,
    output logic [31:0] digest_word1,
    output logic [31:0] digest_word2,
    output logic [31:0] digest_word3,
    output logic [31:0] digest_word4
);
    import sha1md_pkg::*;

    // command and status bundles between the state machine and the datapath
    cmd_t    cmd;
    status_t status;

    // the controller walks through byte collection, padding (0x80 mark, zeros up to
    // byte 56, eight big-endian length bytes), the 80 rounds and the final digest load;
    // padding compresses one or two more blocks
    sha1md_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .msg_valid (msg_valid),
        .msg_stall (msg_stall),
        .has_byte  (has_byte),
        .last      (last),
        .status    (status),
        .cmd       (cmd)
    );

    // the datapath keeps the block in a 16-word shift line that doubles as the
    // message schedule, one shared round unit, the chaining words and the
    // output register, so a finished digest can wait while new bytes come in
    sha1md_datapath u_datapath (
        .clk          (clk),
        .rst_n        (rst_n),
        .cmd          (cmd),
        .status       (status),
        .data_byte    (data_byte),
        .digest_stall (digest_stall),
        .digest_valid (digest_valid),
        .digest_word0 (digest_word0),
        .digest_word1 (digest_word1),
        .digest_word2 (digest_word2),
        .digest_word3 (digest_word3),
        .digest_word4 (digest_word4)
    );

    // no byte may be taken while the round unit owns the shift line
    `SHA1MD_ASSERT_IMP(a_no_accept_in_rounds, clk, rst_n, cmd.round_en, msg_stall)
    // a pending digest is never overwritten
    `SHA1MD_ASSERT_IMP(a_no_digest_overwrite, clk, rst_n, cmd.load_digest, !(digest_valid && digest_stall))
    // the chaining add follows the last round directly
    `SHA1MD_ASSERT_NXT(a_chain_after_rounds, clk, rst_n, cmd.round_en && status.round_last, cmd.chain_add)

endmodule

`default_nettype wire

@@ tb/sha1_message_digest_tb.sv @@
// self-checking testbench for the sha-1 message digest block
`timescale 1ns / 100ps

module sha1_message_digest_tb;

    // sha-1 initial chaining words and per-stage round constants
    localparam logic [31:0] InitH [5] = '{
        32'h67452301, 32'hefcdab89, 32'h98badcfe, 32'h10325476, 32'hc3d2e1f0
    };
    localparam logic [31:0] StageK [4] = '{
        32'h5a827999, 32'h6ed9eba1, 32'h8f1bbcdc, 32'hca62c1d6
    };
    localparam logic [7:0] PadMark = 8'h80;
    localparam int unsigned LenSlot = 56;

    // message lengths around the padding and block boundaries
    localparam int unsigned BoundaryLens [10] = '{54, 55, 56, 57, 63, 64, 65, 119, 120, 128};

    // digest receiver hold-off used to back the block up into its byte input
    localparam int unsigned LongHoldCycles = 1000;
    // settle time after the last digest, longer than two compressions plus padding
    localparam int unsigned DrainCycles = 300;

    typedef struct packed {
        logic [7:0] data;
        logic       has;
        logic       ends;
    } msg_request_t;

    // word 0 in the low slot, same order as the digest ports
    typedef logic [4:0][31:0] digest_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        msg_valid = 1'b0;
    logic        msg_stall;
    logic [7:0]  data_byte = 8'h00;
    logic        has_byte = 1'b0;
    logic        last = 1'b0;
    logic        digest_valid;
    logic        digest_stall = 1'b0;
    logic [31:0] digest_word0;
    logic [31:0] digest_word1;
    logic [31:0] digest_word2;
    logic [31:0] digest_word3;
    logic [31:0] digest_word4;

    sha1_message_digest dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .msg_valid    (msg_valid),
        .msg_stall    (msg_stall),
        .data_byte    (data_byte),
        .has_byte     (has_byte),
        .last         (last),
        .digest_valid (digest_valid),
        .digest_stall (digest_stall),
        .digest_word0 (digest_word0),
        .digest_word1 (digest_word1),
        .digest_word2 (digest_word2),
        .digest_word3 (digest_word3),
        .digest_word4 (digest_word4)
    );

    always #6 clk = ~clk;

    // byte requests waiting to be driven, and digests the block still owes us
    msg_request_t byte_requests_q [$];
    digest_t      pending_digests [$];

    // running hash state mirrored from the block
    logic [31:0] hash_h [5];
    logic [7:0]  hash_buf [64];
    int unsigned hash_fill;
    logic [63:0] hash_bits;

    // idle percentages per phase, set by the stimulus process
    int unsigned send_idle_pct = 0;
    int unsigned recv_idle_pct = 0;
    // toggled by the stimulus process to start one long digest hold-off
    logic        hold_req = 1'b0;

    int unsigned queued_items = 0;
    int unsigned queued_msgs = 0;
    int unsigned errors = 0;

    // coverage tallies for the closing summary
    int unsigned msgs_hashed = 0;
    int unsigned empty_msgs = 0;
    int unsigned bytes_hashed = 0;
    int unsigned filler_reqs = 0;
    int unsigned digests_checked = 0;
    int unsigned input_stall_cycles = 0;
    int unsigned digest_hold_cycles = 0;

    // ---------------------------------------------------------------
    // sha-1 prediction
    // ---------------------------------------------------------------

    function automatic logic [31:0] rol32(input logic [31:0] x, input int unsigned n);
        return (x << n) | (x >> (32 - n));
    endfunction

    task automatic reset_hash_state();
        for (int i = 0; i < 5; i++)
            hash_h[i] = InitH[i];
        hash_fill = 0;
        hash_bits = '0;
    endtask

    // 80-round compression of the 64 collected bytes into the chaining words
    task automatic compress_hash_block();
        logic [31:0] w [80];
        logic [31:0] a, b, c, d, e, f, k, t;
        for (int i = 0; i < 16; i++)
            w[i] = {hash_buf[4*i], hash_buf[4*i+1], hash_buf[4*i+2], hash_buf[4*i+3]};
        for (int i = 16; i < 80; i++)
            w[i] = rol32(w[i-3] ^ w[i-8] ^ w[i-14] ^ w[i-16], 1);
        a = hash_h[0];
        b = hash_h[1];
        c = hash_h[2];
        d = hash_h[3];
        e = hash_h[4];
        for (int i = 0; i < 80; i++)
        begin
            if (i < 20)
                f = (b & c) ^ (~b & d);
            else if (i < 40)
                f = b ^ c ^ d;
            else if (i < 60)
                f = (b & c) ^ (b & d) ^ (c & d);
            else
                f = b ^ c ^ d;
            k = StageK[i / 20];
            t = rol32(a, 5) + f + e + k + w[i];
            e = d;
            d = c;
            c = rol32(b, 30);
            b = a;
            a = t;
        end
        hash_h[0] += a;
        hash_h[1] += b;
        hash_h[2] += c;
        hash_h[3] += d;
        hash_h[4] += e;
    endtask

    task automatic append_hash_byte(input logic [7:0] v);
        hash_buf[hash_fill] = v;
        hash_fill++;
        if (hash_fill == 64)
        begin
            compress_hash_block();
            hash_fill = 0;
        end
    endtask

    // fold one accepted request into the hash; a closing request queues its digest
    task automatic absorb_request(input msg_request_t r);
        logic [63:0] msg_len;
        digest_t     d;
        if (r.has)
        begin
            hash_bits += 64'd8;
            append_hash_byte(r.data);
        end
        if (r.ends)
        begin
            msg_len = hash_bits;
            append_hash_byte(PadMark);
            while (hash_fill != LenSlot)
                append_hash_byte(8'h00);
            for (int i = 0; i < 8; i++)
                append_hash_byte(8'(msg_len >> (56 - 8 * i)));
            for (int i = 0; i < 5; i++)
                d[i] = hash_h[i];
            pending_digests.push_back(d);
            reset_hash_state();
        end
    endtask

    // ---------------------------------------------------------------
    // stimulus helpers
    // ---------------------------------------------------------------

    // idle length: none most of the time, short bursts, now and then a long one
    function automatic int unsigned pick_gap(input int unsigned pct);
        if ($urandom_range(99) >= pct)
            return 0;
        if ($urandom_range(9) == 0)
            return $urandom_range(60, 20);
        return $urandom_range(3, 1);
    endfunction

    function automatic int unsigned pick_msg_len();
        int unsigned sel;
        sel = $urandom_range(9);
        if (sel < 3)
            return BoundaryLens[$urandom_range(9)];
        if (sel < 8)
            return $urandom_range(12);
        return $urandom_range(130);
    endfunction

    task automatic push_request(input logic [7:0] data, input logic has, input logic ends);
        msg_request_t r;
        r.data = data;
        r.has  = has;
        r.ends = ends;
        byte_requests_q.push_back(r);
        if (has || ends)
            queued_items++;
        if (ends)
            queued_msgs++;
    endtask

    // one message of random bytes; the closing flag rides on the final byte
    // or on a separate request without a byte; filler requests sprinkled in
    task automatic queue_message(input int unsigned len, input bit close_on_byte,
                                 input int unsigned filler_pct);
        for (int unsigned i = 0; i < len; i++)
        begin
            if ($urandom_range(99) < filler_pct)
                push_request(8'($urandom_range(255)), 1'b0, 1'b0);
            push_request(8'($urandom_range(255)), 1'b1, close_on_byte && (i == len - 1));
        end
        if (!close_on_byte || len == 0)
            push_request(8'($urandom_range(255)), 1'b0, 1'b1);
    endtask

    task automatic queue_random_messages(input int unsigned n_items, input int unsigned n_msgs);
        int unsigned item_goal, msg_goal;
        item_goal = queued_items + n_items;
        msg_goal  = queued_msgs + n_msgs;
        while (queued_items < item_goal || queued_msgs < msg_goal)
            queue_message(pick_msg_len(), 1'($urandom_range(1)),
                          ($urandom_range(99) < 15) ? 10 : 0);
    endtask

    // sender stays quiet until every request is taken and every digest is back
    task automatic wait_until_drained();
        while (byte_requests_q.size() != 0 || msg_valid || pending_digests.size() != 0)
            @(negedge clk);
    endtask

    // ---------------------------------------------------------------
    // request driver: pops the queue, holds a stalled request, inserts gaps
    // ---------------------------------------------------------------

    int unsigned send_gap;

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            msg_valid <= 1'b0;
            data_byte <= 8'h00;
            has_byte  <= 1'b0;
            last      <= 1'b0;
            send_gap  <= 0;
            reset_hash_state();
        end
        else
        begin
            // request taken at this edge: update the prediction
            if (msg_valid && !msg_stall)
            begin
                if (has_byte)
                    bytes_hashed++;
                if (!has_byte && !last)
                    filler_reqs++;
                if (last)
                begin
                    msgs_hashed++;
                    if (!has_byte && hash_bits == 64'd0)
                        empty_msgs++;
                end
                absorb_request('{data: data_byte, has: has_byte, ends: last});
            end

            if (msg_valid && msg_stall)
            begin
                // payload stays put until the block takes it
                input_stall_cycles++;
            end
            else if (send_gap != 0)
            begin
                msg_valid <= 1'b0;
                send_gap  <= send_gap - 1;
            end
            else if (byte_requests_q.size() != 0)
            begin
                msg_request_t nxt;
                nxt = byte_requests_q.pop_front();
                msg_valid <= 1'b1;
                data_byte <= nxt.data;
                has_byte  <= nxt.has;
                last      <= nxt.ends;
                send_gap  <= pick_gap(send_idle_pct);
            end
            else
            begin
                msg_valid <= 1'b0;
            end
        end
    end

    // ---------------------------------------------------------------
    // digest monitor and receiver stall
    // ---------------------------------------------------------------

    digest_t     seen_digest;
    digest_t     want_digest;
    int unsigned hold_left;
    int unsigned stall_left;
    logic        hold_seen;

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            digest_stall <= 1'b0;
            hold_left    <= 0;
            stall_left   <= 0;
            hold_seen    <= 1'b0;
        end
        else
        begin
            if (digest_valid && digest_stall)
                digest_hold_cycles++;

            // digest request taken: compare word by word with the oldest prediction
            if (digest_valid && !digest_stall)
            begin
                seen_digest = {digest_word4, digest_word3, digest_word2,
                               digest_word1, digest_word0};
                if (pending_digests.size() == 0)
                begin
                    $error("digest %h arrived with no message outstanding", seen_digest);
                    errors++;
                end
                else
                begin
                    want_digest = pending_digests.pop_front();
                    for (int i = 0; i < 5; i++)
                    begin
                        if (seen_digest[i] !== want_digest[i])
                        begin
                            $error("digest_word%0d: expected %h, got %h",
                                   i, want_digest[i], seen_digest[i]);
                            errors++;
                        end
                    end
                    digests_checked++;
                end
            end

            // a new hold request wins over the random stall pattern
            if (hold_req != hold_seen)
            begin
                hold_seen    <= hold_req;
                hold_left    <= LongHoldCycles - 1;
                digest_stall <= 1'b1;
            end
            else if (hold_left != 0)
            begin
                hold_left    <= hold_left - 1;
                digest_stall <= 1'b1;
            end
            else if (stall_left != 0)
            begin
                stall_left   <= stall_left - 1;
                digest_stall <= 1'b1;
            end
            else
            begin
                int unsigned g;
                g = pick_gap(recv_idle_pct);
                stall_left   <= (g != 0) ? g - 1 : 0;
                digest_stall <= (g != 0);
            end
        end
    end

    // ---------------------------------------------------------------
    // stimulus sequence
    // ---------------------------------------------------------------

    initial
    begin
        // directed: filler requests, empty messages, closing flag with and
        // without a byte, all-zero and all-one bytes
        push_request(8'hff, 1'b0, 1'b0);
        push_request(8'h00, 1'b0, 1'b1);
        push_request(8'h00, 1'b1, 1'b0);
        push_request(8'hff, 1'b1, 1'b1);
        push_request(8'ha5, 1'b0, 1'b0);
        push_request(8'hff, 1'b1, 1'b0);
        push_request(8'h00, 1'b0, 1'b1);
        push_request(8'h00, 1'b1, 1'b1);
        push_request(8'hff, 1'b0, 1'b1);
        push_request(8'h80, 1'b1, 1'b0);
        push_request(8'h7f, 1'b1, 1'b0);
        push_request(8'h5a, 1'b0, 1'b0);
        push_request(8'h01, 1'b1, 1'b0);
        push_request(8'hfe, 1'b1, 1'b1);
        push_request(8'hff, 1'b1, 1'b0);
        push_request(8'h00, 1'b1, 1'b0);
        push_request(8'h00, 1'b0, 1'b1);

        repeat (7) @(posedge clk);
        rst_n <= 1'b1;

        @(negedge clk);
        send_idle_pct = 20;
        recv_idle_pct = 20;
        wait_until_drained();

        // random messages with idling on both sides
        queue_random_messages(240, 5);
        wait_until_drained();

        // back to back, no idling anywhere
        send_idle_pct = 0;
        recv_idle_pct = 0;
        queue_random_messages(160, 4);
        wait_until_drained();

        // digest side holds off for a long stretch while short messages keep
        // coming, so the block has to back up into its byte input
        hold_req = ~hold_req;
        for (int i = 0; i < 8; i++)
            queue_message($urandom_range(4), 1'($urandom_range(1)), 0);
        wait_until_drained();

        // heavy idling on both sides
        send_idle_pct = 40;
        recv_idle_pct = 40;
        queue_random_messages(200, 5);
        wait_until_drained();

        repeat (DrainCycles) @(negedge clk);
        if (pending_digests.size() != 0)
        begin
            $error("%0d digests never arrived", pending_digests.size());
            errors++;
        end

        $display("summary: %0d messages hashed (%0d empty), %0d bytes, %0d filler requests",
                 msgs_hashed, empty_msgs, bytes_hashed, filler_reqs);
        $display("summary: %0d digests compared, input stalled %0d cycles, digest held %0d cycles",
                 digests_checked, input_stall_cycles, digest_hold_cycles);
        if (errors == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

    // watchdog, far beyond the slowest legal run
    initial
    begin
        #6_000_000;
        $display("FAIL");
        $finish;
    end

endmodule
